/* design/tpq_pkg.sv */
// Package for the typed pending queue: field widths, operation and status
// codes, compare opcodes and the packed slot layout. No dependencies.
`default_nettype none

package tpq_pkg;

  localparam int TYPE_W    = 3;
  localparam int SOURCE_W  = 15;
  localparam int HANDLE_W  = 32;
  localparam int OUT_SRC_W = 16;
  localparam int OCC_W     = 5;

  // Type codes 1..NUM_TYPES are valid; fixed by the 3-bit type field.
  localparam int NUM_TYPES = 7;
  localparam int TIDX_W    = $clog2(NUM_TYPES);

  localparam int DEPTH_DEF = 16;

  localparam logic signed [OUT_SRC_W-1:0] SOURCE_NONE = -16'sd1;

  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_TAKE  = 2'd1,
    FUNC_QUERY = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NOMATCH = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic {
    CMP_EQ = 1'b0,
    CMP_GT = 1'b1
  } cmp_op_t;

  typedef struct packed {
    logic [TYPE_W-1:0]   slot_type;
    logic [SOURCE_W-1:0] slot_source;
    logic [HANDLE_W-1:0] slot_uri;
    logic [HANDLE_W-1:0] slot_separator;
  } slot_t;

endpackage

`default_nettype wire

/* design/tpq_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module tpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* design/tpq_cmp.sv */
// Shared compare unit: type equality during a take search, count
// greater-than during a query scan. Depends on tpq_pkg.
`default_nettype none

module tpq_cmp
  import tpq_pkg::*;
#(
  parameter int W = 8
) (
  input  wire cmp_op_t        op,
  input  wire logic [W-1:0]   a,
  input  wire logic [W-1:0]   b,
  output logic                hit
);

  always_comb begin
    case (op)
      CMP_EQ:  hit = (a == b);
      CMP_GT:  hit = (a > b);
      default: hit = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

/* design/typed_pending_queue.sv */
// Typed pending queue top level: sequencer, slot RAM, per-type counters.
// Depends on tpq_pkg, tpq_ram and tpq_cmp.
//
// Job channel (job_valid / job_stall): one transaction carries func, job_type,
// source_id, uri_handle and separator_handle. Add appends a job, take removes
// the oldest job of job_type and closes the gap, query reports the type with
// the most waiting jobs (lowest type on ties, 0 if none).
// Result channel (result_valid / result_stall): exactly one result transaction
// per job transaction, in order: status, out_type, out_source, out_uri,
// out_separator and occupancy after the operation.
// Timing: one operation at a time; job_stall is high from acceptance until the
// result is loaded into the output register. Add, invalid type and unused func
// go straight to the finish state. Query compares one counter a cycle. Take
// uses one RAM read and one write port, so the search walks one slot a cycle
// and the compaction moves one slot a cycle.
// Reset: synchronous, active high; clears occupancy and the type counters. The
// slot RAM is not cleared (only slots below the occupancy are read), so a job
// is accepted in the first cycle after reset.
// Backpressure: while result_stall is high a finished result waits in the output
// register; the next operation completes and holds in its final state until
// the output register frees up.
`default_nettype none

module typed_pending_queue
  import tpq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,

  input  wire logic                        job_valid,
  output logic                             job_stall,
  input  wire logic [1:0]                  func,
  input  wire logic [TYPE_W-1:0]           job_type,
  input  wire logic [SOURCE_W-1:0]         source_id,
  input  wire logic [HANDLE_W-1:0]         uri_handle,
  input  wire logic [HANDLE_W-1:0]         separator_handle,

  output logic                             result_valid,
  input  wire logic                        result_stall,
  output logic [1:0]                       status,
  output logic [TYPE_W-1:0]                out_type,
  output logic signed [OUT_SRC_W-1:0]      out_source,
  output logic [HANDLE_W-1:0]              out_uri,
  output logic [HANDLE_W-1:0]              out_separator,
  output logic [OCC_W-1:0]                 occupancy
);

  localparam int AW     = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int CNT_W  = FILL_W;
  localparam int CMP_W  = (CNT_W > TYPE_W) ? CNT_W : TYPE_W;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_SHIFT  = 5'b00100,
    S_QUERY  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state;

  // Control registers
  logic [FILL_W-1:0] fill;
  logic [CNT_W-1:0]  cnt [NUM_TYPES];
  logic [FILL_W-1:0] rd_ptr;     // next slot to read in search
  logic              pend;       // read data in flight for search
  logic [AW-1:0]     pend_idx;
  logic [FILL_W-1:0] sp;         // next slot to read in compaction
  logic              wpend;      // compaction write pending
  logic [AW-1:0]     waddr;
  logic [TIDX_W-1:0] qidx;

  // Operation payload
  logic [TYPE_W-1:0] jt;
  logic [TYPE_W-1:0] best;
  logic [CNT_W-1:0]  best_cnt;

  // Pending result
  status_t                      res_status;
  logic [TYPE_W-1:0]            res_type;
  logic signed [OUT_SRC_W-1:0]  res_source;
  logic [HANDLE_W-1:0]          res_uri;
  logic [HANDLE_W-1:0]          res_sep;

  // RAM ports
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  slot_t         wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  slot_t         rd_data;

  // Shared compare unit
  cmp_op_t           cmp_op;
  logic [CMP_W-1:0]  cmp_a;
  logic [CMP_W-1:0]  cmp_b;
  logic              cmp_hit;

  logic [TIDX_W-1:0] cnt_addr;
  logic [CNT_W-1:0]  cnt_rd;
  logic [TIDX_W-1:0] jt_idx;
  logic [TIDX_W-1:0] in_idx;
  logic              in_type_ok;
  logic              full;
  logic              out_free;
  logic              add_ok;
  logic              q_last;

  assign job_stall  = (state != S_IDLE);
  assign out_free   = !result_valid || !result_stall;
  assign full       = (fill == FILL_W'(DEPTH));
  assign in_type_ok = (job_type != '0) && (job_type <= TYPE_W'(NUM_TYPES));
  assign in_idx     = TIDX_W'(job_type - TYPE_W'(1));
  assign jt_idx     = TIDX_W'(jt - TYPE_W'(1));
  assign add_ok     = (state == S_IDLE) && job_valid && (func_t'(func) == FUNC_ADD)
                      && in_type_ok && !full;
  assign q_last     = (qidx == TIDX_W'(NUM_TYPES - 1));

  // Single read port on the counter file
  always_comb begin
    case (state)
      S_IDLE:  cnt_addr = in_idx;
      S_QUERY: cnt_addr = qidx;
      default: cnt_addr = jt_idx;
    endcase
  end
  assign cnt_rd = cnt[cnt_addr];

  always_comb begin
    if (state == S_QUERY) begin
      cmp_op = CMP_GT;
      cmp_a  = CMP_W'(cnt_rd);
      cmp_b  = CMP_W'(best_cnt);
    end else begin
      cmp_op = CMP_EQ;
      cmp_a  = CMP_W'(rd_data.slot_type);
      cmp_b  = CMP_W'(jt);
    end
  end

  tpq_cmp #(
    .W (CMP_W)
  ) u_cmp (
    .op  (cmp_op),
    .a   (cmp_a),
    .b   (cmp_b),
    .hit (cmp_hit)
  );

  // RAM port steering: appends from idle, search reads, compaction reads/moves
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = fill[AW-1:0];
    wr_data = '{slot_type:      job_type,
                slot_source:    source_id,
                slot_uri:       uri_handle,
                slot_separator: separator_handle};
    if (add_ok) begin
      wr_en = 1'b1;
    end else if ((state == S_SHIFT) && wpend) begin
      wr_en   = 1'b1;
      wr_addr = waddr;
      wr_data = rd_data;
    end

    rd_en   = 1'b0;
    rd_addr = rd_ptr[AW-1:0];
    if (state == S_SEARCH) begin
      rd_en = !(pend && cmp_hit) && (rd_ptr < fill);
    end else if (state == S_SHIFT) begin
      rd_en   = (sp < fill);
      rd_addr = sp[AW-1:0];
    end
  end

  tpq_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fill         <= '0;
      pend         <= 1'b0;
      wpend        <= 1'b0;
      result_valid <= 1'b0;
      for (int t = 0; t < NUM_TYPES; t++) begin
        cnt[t] <= '0;
      end
    end else begin
      // Output register: load from finish, drop once the receiver takes it
      if ((state == S_FINISH) && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (job_valid) begin
            jt         <= job_type;
            res_type   <= '0;
            res_source <= SOURCE_NONE;
            res_uri    <= '0;
            res_sep    <= '0;
            case (func_t'(func))
              FUNC_ADD: begin
                if (!in_type_ok) begin
                  res_status <= ST_INVALID;
                end else if (full) begin
                  res_status <= ST_FULL;
                end else begin
                  res_status     <= ST_OK;
                  fill           <= fill + FILL_W'(1);
                  cnt[in_idx]    <= cnt_rd + CNT_W'(1);
                end
                state <= S_FINISH;
              end
              FUNC_TAKE: begin
                if (!in_type_ok) begin
                  res_status <= ST_INVALID;
                  state      <= S_FINISH;
                end else begin
                  res_status <= ST_OK;
                  rd_ptr     <= '0;
                  pend       <= 1'b0;
                  state      <= S_SEARCH;
                end
              end
              FUNC_QUERY: begin
                res_status <= ST_OK;
                qidx       <= '0;
                best       <= '0;
                best_cnt   <= '0;
                state      <= S_QUERY;
              end
              default: begin
                res_status <= ST_OK;
                state      <= S_FINISH;
              end
            endcase
          end
        end

        // Walk slots oldest first; data for pend_idx arrives this cycle
        S_SEARCH: begin
          if (pend && cmp_hit) begin
            res_type   <= jt;
            res_source <= OUT_SRC_W'(rd_data.slot_source);
            res_uri    <= rd_data.slot_uri;
            res_sep    <= rd_data.slot_separator;
            sp         <= FILL_W'(pend_idx) + FILL_W'(1);
            wpend      <= 1'b0;
            pend       <= 1'b0;
            state      <= S_SHIFT;
          end else if (rd_ptr >= fill) begin
            res_status <= ST_NOMATCH;
            pend       <= 1'b0;
            state      <= S_FINISH;
          end else begin
            rd_ptr   <= rd_ptr + FILL_W'(1);
            pend     <= 1'b1;
            pend_idx <= rd_ptr[AW-1:0];
          end
        end

        // Move each later slot down by one: read sp, write sp-1 next cycle
        S_SHIFT: begin
          if (sp < fill) begin
            sp    <= sp + FILL_W'(1);
            wpend <= 1'b1;
            waddr <= AW'(sp - FILL_W'(1));
          end else begin
            wpend <= 1'b0;
            if (!wpend) begin
              fill <= fill - FILL_W'(1);
              if (cnt_rd != '0) begin
                cnt[jt_idx] <= cnt_rd - CNT_W'(1);
              end
              state <= S_FINISH;
            end
          end
        end

        // One type counter per cycle; strict greater keeps the lowest type
        S_QUERY: begin
          if (cmp_hit) begin
            best     <= TYPE_W'(qidx) + TYPE_W'(1);
            best_cnt <= cnt_rd;
          end
          if (q_last) begin
            res_type <= cmp_hit ? (TYPE_W'(qidx) + TYPE_W'(1)) : best;
            state    <= S_FINISH;
          end else begin
            qidx <= qidx + TIDX_W'(1);
          end
        end

        S_FINISH: begin
          if (out_free) begin
            status        <= res_status;
            out_type      <= res_type;
            out_source    <= res_source;
            out_uri       <= res_uri;
            out_separator <= res_sep;
            occupancy     <= OCC_W'(fill);
            state         <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(DEPTH))
    else $error("occupancy above depth");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_FINISH))
    else $error("result loaded outside finish state");

  a_fill_change: assert property (@(posedge clk) disable iff (rst)
    (fill != $past(fill)) |-> ($past(state == S_IDLE) || $past(state == S_SHIFT)))
    else $error("occupancy changed outside add or take");

  a_pend_search: assert property (@(posedge clk) disable iff (rst)
    pend |-> (state == S_SEARCH))
    else $error("search read pending outside search");

endmodule

`default_nettype wire
